[design/binary_patch_apply_macros.svh]
// Assertion macros for binary_patch_apply
`ifndef BINARY_PATCH_APPLY_MACROS_SVH
`define BINARY_PATCH_APPLY_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BPA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BPA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define BPA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[design/bpa_pkg.sv]
package bpa_pkg;
    localparam int unsigned HdrBytes = 32;
    localparam logic [1:0] OP_LOAD_OLD   = 2'd0;
    localparam logic [1:0] OP_LOAD_PATCH = 2'd1;
    localparam logic [1:0] OP_START      = 2'd2;
    localparam logic [1:0] OP_STEP       = 2'd3;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BYTE = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;
    localparam logic [16:0] MaxNew = 17'd65536;
    typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_DONE, PH_ERR} t_phase;
endpackage

[design/binary_patch_apply.sv]
// channel | signals                              | accepted when
// in      | i_valid, o_stall, i_opcode.. data    | i_valid && !o_stall
// out     | o_valid, i_stall, o_status.. is_last | o_valid && !i_stall
// cfg     | psel, penable, pwrite, paddr, pwdata | psel && penable && pwrite
// Start reads 24 header bytes, one patch-memory read a cycle. A byte step
// also fetches a control triple (24 serial byte reads) whenever the last one
// is used up. One byte shifter/adder does it.
// Reset: synchronous, active low; memories are not cleared.
// o_stall is high from acceptance until the result has been taken.
`include "binary_patch_apply_macros.svh"
module binary_patch_apply
    import bpa_pkg::*;
#(
    parameter int unsigned OLD_DEPTH = 65536,
    parameter int unsigned PATCH_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_out_index,
    output logic        o_is_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int OAW = (OLD_DEPTH > 1) ? $clog2(OLD_DEPTH) : 1;
    localparam int PAW = (PATCH_DEPTH > 1) ? $clog2(PATCH_DEPTH) : 1;
    localparam logic [16:0] OldLim =
        (OLD_DEPTH >= 131071) ? 17'h1FFFF : 17'(OLD_DEPTH);
    localparam logic [16:0] PatLim =
        (PATCH_DEPTH >= 131071) ? 17'h1FFFF : 17'(PATCH_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_HREAD, S_HCHK, S_STEP, S_TREAD, S_TCHK,
        S_BREAD, S_BWAIT, S_BCALC, S_OUT
    } t_state;

    logic [7:0] r_old_mem [OLD_DEPTH];
    logic [7:0] r_pat_mem [PATCH_DEPTH];
    logic [7:0] r_old_rd, r_pat_rd;

    t_state r_state;
    t_phase r_phase;
    logic [16:0] r_old_len, r_pat_len;
    logic [16:0] r_ctrl_len, r_diff_len, r_new_len, r_new_pos;
    logic [63:0] r_old_pos, r_seek;
    logic [16:0] r_ctrl_off, r_diff_off, r_extra_off, r_diff_rem, r_extra_rem;
    logic [63:0] r_val [3];
    logic [4:0]  r_cnt;
    logic [17:0] r_rd_addr;
    logic        r_rd_en;
    logic        r_from_diff;
    logic [1:0]  r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    logic [16:0] eff_old, eff_pat;
    assign eff_old = (r_old_len < OldLim) ? r_old_len : OldLim;
    assign eff_pat = (r_pat_len < PatLim) ? r_pat_len : PatLim;

    // pready fixed high; reads return stored lengths
    assign pready = 1'b1;
    assign prdata = (paddr[2] ? {15'd0, r_pat_len} : {15'd0, r_old_len});

    // serial byte read: captured byte goes into the value register selected by count
    logic [1:0] v_sel;
    logic [2:0] v_byte;
    assign v_sel  = r_cnt[4:3] == 2'd3 ? 2'd2 : r_cnt[4:3];
    assign v_byte = r_cnt[2:0];

    always_ff @(posedge i_clk) begin
        if (r_op == OP_LOAD_OLD && r_state == S_IDLE && 1'b0) begin
        end
    end

    logic [63:0] m0, m1, m2;
    logic n0, n1, n2;
    assign m0 = {1'b0, r_val[0][62:0]};
    assign m1 = {1'b0, r_val[1][62:0]};
    assign m2 = {1'b0, r_val[2][62:0]};
    assign n0 = r_val[0][63] && m0 != 64'd0;
    assign n1 = r_val[1][63] && m1 != 64'd0;
    assign n2 = r_val[2][63] && m2 != 64'd0;

    logic [17:0] ebase, eavail, room;
    assign ebase  = 18'(HdrBytes) + {1'b0, r_ctrl_len} + {1'b0, r_diff_len};
    assign eavail = ({1'b0, eff_pat} > ebase) ? {1'b0, eff_pat} - ebase : 18'd0;
    assign room   = {1'b0, r_new_len} - {1'b0, r_new_pos};

    logic old_in;
    assign old_in = (r_old_pos[63:17] == 47'd0) && (r_old_pos[16:0] < eff_old);

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        // memories: one write and one registered read each
        if (r_state == S_IDLE && i_valid && !o_stall && i_opcode == OP_LOAD_OLD
            && 32'(i_address) < OLD_DEPTH)
            r_old_mem[OAW'(i_address)] <= i_data_byte;
        if (r_state == S_IDLE && i_valid && !o_stall && i_opcode == OP_LOAD_PATCH
            && 32'(i_address) < PATCH_DEPTH)
            r_pat_mem[PAW'(i_address)] <= i_data_byte;
        r_old_rd <= r_old_mem[OAW'(r_old_pos)];
        if (r_rd_addr < 18'(PATCH_DEPTH) || PATCH_DEPTH >= 262144)
            r_pat_rd <= r_pat_mem[PAW'(r_rd_addr)];
        else
            r_pat_rd <= 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_old_len <= '0; r_pat_len <= '0;
            r_ctrl_len <= '0; r_diff_len <= '0; r_new_len <= '0; r_new_pos <= '0;
            r_old_pos <= '0; r_seek <= '0;
            r_ctrl_off <= '0; r_diff_off <= '0; r_extra_off <= '0;
            r_diff_rem <= '0; r_extra_rem <= '0;
            r_cnt <= '0; r_rd_en <= 1'b0;
            o_valid <= 1'b0;
            o_status <= ST_OK; o_out_byte <= '0; o_out_index <= '0; o_is_last <= 1'b0;
        end else begin
            if (cfg_wr && paddr == 3'd0) r_old_len <= pwdata[16:0];
            if (cfg_wr && paddr == 3'd4) r_pat_len <= pwdata[16:0];
            r_rd_en <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_opcode;
                        r_addr <= i_address;
                        r_data <= i_data_byte;
                        o_status <= ST_OK; o_out_byte <= '0;
                        o_out_index <= '0; o_is_last <= 1'b0;
                        case (i_opcode)
                            OP_START: begin
                                r_cnt <= '0;
                                r_rd_addr <= 18'd8;
                                r_rd_en <= 1'b1;
                                r_state <= S_HREAD;
                            end
                            OP_STEP: r_state <= S_STEP;
                            default: begin
                                o_valid <= 1'b1;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_HREAD, S_TREAD: begin
                    // one byte a cycle; r_cnt counts captured bytes
                    if (!r_rd_en && r_cnt == 5'd0 && r_rd_addr[17] == 1'b1) begin
                    end
                    if (r_rd_en || r_cnt != 5'd0 || 1'b1) begin
                        if (r_rd_en) begin
                            r_rd_addr <= r_rd_addr + 18'd1;
                            r_rd_en <= (r_cnt != 5'd23) && (r_cnt != 5'd22 || 1'b1);
                        end
                    end
                    if (r_state == r_state) begin end
                    // capture previous cycle's read
                    if (r_cnt[4:0] != 5'd31 && r_phase_cap) begin
                        r_val[v_sel][8*v_byte +: 8] <= r_pat_rd;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd23)
                            r_state <= (r_state == S_HREAD) ? S_HCHK : S_TCHK;
                    end
                    if (r_cnt >= 5'd22 && r_rd_en) r_rd_en <= 1'b0;
                end
                S_HCHK: begin
                    r_old_pos <= '0; r_new_pos <= '0; r_seek <= '0;
                    r_ctrl_off <= '0; r_diff_off <= '0; r_extra_off <= '0;
                    r_diff_rem <= '0; r_extra_rem <= '0;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                    if (eff_pat < 17'(HdrBytes) || n0 || n1 || n2 ||
                        m2 > 64'(MaxNew) || m0 > 64'(eff_pat) || m1 > 64'(eff_pat) ||
                        64'(HdrBytes) + m0 + m1 > 64'(eff_pat)) begin
                        r_phase <= PH_ERR;
                        o_status <= ST_ERR;
                        r_ctrl_len <= '0; r_diff_len <= '0; r_new_len <= '0;
                    end else begin
                        r_ctrl_len <= m0[16:0];
                        r_diff_len <= m1[16:0];
                        r_new_len <= m2[16:0];
                        r_phase <= PH_RUN;
                    end
                end
                S_STEP: begin
                    if (r_phase == PH_IDLE || r_phase == PH_ERR) begin
                        o_status <= ST_ERR; o_valid <= 1'b1; r_state <= S_OUT;
                    end else if (r_phase == PH_DONE || r_new_pos >= r_new_len) begin
                        r_phase <= PH_DONE;
                        o_status <= ST_DONE; o_valid <= 1'b1; r_state <= S_OUT;
                    end else if (r_diff_rem == '0 && r_extra_rem == '0) begin
                        if (r_ctrl_off > r_ctrl_len ||
                            r_ctrl_len - r_ctrl_off < 17'd24) begin
                            r_phase <= PH_ERR;
                            o_status <= ST_ERR; o_valid <= 1'b1; r_state <= S_OUT;
                        end else begin
                            r_cnt <= '0;
                            r_rd_addr <= 18'(HdrBytes) + {1'b0, r_ctrl_off};
                            r_rd_en <= 1'b1;
                            r_state <= S_TREAD;
                        end
                    end else begin
                        r_from_diff <= r_diff_rem != '0;
                        r_rd_addr <= (r_diff_rem != '0)
                            ? 18'(HdrBytes) + {1'b0, r_ctrl_len} + {1'b0, r_diff_off}
                            : ebase + {1'b0, r_extra_off};
                        r_state <= S_BREAD;
                    end
                end
                S_TCHK: begin
                    r_ctrl_off <= r_ctrl_off + 17'd24;
                    if (n0 || n1 || m0 > 64'(room) || m1 > 64'(room) - m0 ||
                        m0 > 64'(r_diff_len - r_diff_off) ||
                        {1'b0, r_extra_off} > eavail ||
                        m1 > 64'(eavail - {1'b0, r_extra_off})) begin
                        r_phase <= PH_ERR;
                        o_status <= ST_ERR; o_valid <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_old_pos <= r_old_pos + r_seek;
                        r_seek <= n2 ? 64'd0 - m2 : m2;
                        r_diff_rem <= m0[16:0];
                        r_extra_rem <= m1[16:0];
                        r_state <= S_STEP;
                    end
                end
                S_BREAD: r_state <= S_BWAIT;
                S_BWAIT: r_state <= S_BCALC;
                S_BCALC: begin
                    if (r_from_diff) begin
                        o_out_byte <= r_pat_rd + (old_in ? r_old_rd : 8'd0);
                        r_diff_off <= r_diff_off + 17'd1;
                        r_old_pos <= r_old_pos + 64'd1;
                        r_diff_rem <= r_diff_rem - 17'd1;
                    end else begin
                        o_out_byte <= r_pat_rd;
                        r_extra_off <= r_extra_off + 17'd1;
                        r_extra_rem <= r_extra_rem - 17'd1;
                    end
                    o_status <= ST_BYTE;
                    o_out_index <= r_new_pos[15:0];
                    r_new_pos <= r_new_pos + 17'd1;
                    o_is_last <= (r_new_pos + 17'd1) == r_new_len;
                    if ((r_new_pos + 17'd1) == r_new_len) r_phase <= PH_DONE;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // read data is valid the cycle after a read was issued
    logic r_phase_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase_cap <= 1'b0;
        else r_phase_cap <= r_rd_en;
    end

    assign o_stall = (r_state != S_IDLE);

    `BPA_ASSERT_IMPL(a_out_stall, i_clk, i_rst_n, o_valid, o_stall)
    `BPA_ASSERT_IMPL(a_fields_zero, i_clk, i_rst_n, o_valid && o_status != ST_BYTE,
        o_out_byte == 8'd0 && o_is_last == 1'b0)
    `BPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

[test/binary_patch_apply_tb.sv]
`timescale 1ns / 1ps
module binary_patch_apply_tb;
    import bpa_pkg::*;

    typedef longint unsigned u64;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data;
        logic [15:0] index;
        logic        last;
    } patch_result_t;

    typedef enum int {
        ED_NONE, ED_NEG_COUNT, ED_PAST_NEW, ED_PAST_DIFF, ED_PAST_EXTRA, ED_RUN_OUT,
        ED_HDR_NEG, ED_HDR_NEW_BIG, ED_HDR_OVER, ED_HDR_SHORT, ED_NEW_MAX, ED_NEG_ZERO
    } patch_edit_t;

    localparam logic [2:0] ADDR_OLD_LEN   = 3'd0;
    localparam logic [2:0] ADDR_PATCH_LEN = 3'd4;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_address = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_out_byte;
    logic [15:0] o_out_index;
    logic        o_is_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    binary_patch_apply uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // image of the block's state
    logic [7:0] old_mem   [65536];
    logic [7:0] patch_mem [65536];
    t_phase ph = PH_IDLE;
    u64 reg_old_len = 0, reg_patch_len = 0;
    u64 ctrl_len = 0, diff_len = 0, new_len = 0, new_pos = 0, old_pos = 0;
    u64 ctrl_off = 0, diff_off = 0, extra_off = 0, diff_rem = 0, extra_rem = 0, seek = 0;

    patch_result_t pending_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int n_sent = 0, n_bytes = 0, n_err = 0, n_done = 0, n_patches = 0;
    int burst_left = 0;
    bit gaps_on = 0;
    int stall_mode = 0;
    int stall_tick = 0;

    logic [7:0] pimg[$];
    int ctrl_end;

    function automatic u64 eff_old();
        return reg_old_len < 65536 ? reg_old_len : 65536;
    endfunction

    function automatic u64 eff_patch();
        return reg_patch_len < 65536 ? reg_patch_len : 65536;
    endfunction

    function automatic logic [7:0] patch_rd(u64 a);
        return a < 65536 ? patch_mem[a[15:0]] : 8'h00;
    endfunction

    // 8-byte little-endian sign-magnitude field
    function automatic u64 sm_rd(u64 base, output bit neg);
        u64 m;
        logic [7:0] top;
        top = patch_rd(base + 7);
        m = top & 8'h7F;
        for (int i = 6; i >= 0; i--) m = (m << 8) | patch_rd(base + i);
        neg = top[7] && m != 0;
        return m;
    endfunction

    function automatic bit next_triple();
        u64 ebase, eav, c0, c1, c2, room;
        bit n0, n1, n2;
        ebase = HdrBytes + ctrl_len + diff_len;
        eav = eff_patch() > ebase ? eff_patch() - ebase : 0;
        while (diff_rem == 0 && extra_rem == 0) begin
            if (ctrl_off > ctrl_len || ctrl_len - ctrl_off < 24) return 0;
            c0 = sm_rd(HdrBytes + ctrl_off, n0);
            c1 = sm_rd(HdrBytes + ctrl_off + 8, n1);
            c2 = sm_rd(HdrBytes + ctrl_off + 16, n2);
            ctrl_off += 24;
            if (n0 || n1) return 0;
            room = new_len - new_pos;
            if (c0 > room || c1 > room - c0) return 0;
            if (c0 > diff_len - diff_off) return 0;
            if (extra_off > eav || c1 > eav - extra_off) return 0;
            old_pos += seek;
            seek = n2 ? 0 - c2 : c2;
            diff_rem = c0;
            extra_rem = c1;
        end
        return 1;
    endfunction

    function automatic patch_result_t apply_request(logic [1:0] op, logic [15:0] a,
                                                    logic [7:0] d);
        patch_result_t r;
        bit na, nb, nc;
        u64 x, y, z, plen;
        logic [7:0] v;
        r = '0;
        case (op)
            OP_LOAD_OLD: old_mem[a] = d;
            OP_LOAD_PATCH: patch_mem[a] = d;
            OP_START: begin
                plen = eff_patch();
                x = sm_rd(8, na);
                y = sm_rd(16, nb);
                z = sm_rd(24, nc);
                old_pos = 0; new_pos = 0; seek = 0;
                ctrl_off = 0; diff_off = 0; extra_off = 0; diff_rem = 0; extra_rem = 0;
                ctrl_len = 0; diff_len = 0; new_len = 0;
                if (plen < HdrBytes || na || nb || nc || z > 65536 || x > plen || y > plen
                        || HdrBytes + x + y > plen) begin
                    ph = PH_ERR;
                    r.status = ST_ERR;
                end else begin
                    ctrl_len = x; diff_len = y; new_len = z;
                    ph = PH_RUN;
                end
            end
            default: begin
                if (ph == PH_IDLE || ph == PH_ERR) begin
                    r.status = ST_ERR;
                end else if (ph == PH_DONE || new_pos >= new_len) begin
                    ph = PH_DONE;
                    r.status = ST_DONE;
                end else if (!next_triple()) begin
                    ph = PH_ERR;
                    r.status = ST_ERR;
                end else begin
                    if (diff_rem != 0) begin
                        v = patch_rd(HdrBytes + ctrl_len + diff_off);
                        // old byte outside the image adds nothing
                        if (old_pos < eff_old()) v = v + old_mem[old_pos[15:0]];
                        diff_off++; old_pos++; diff_rem--;
                    end else begin
                        v = patch_rd(HdrBytes + ctrl_len + diff_len + extra_off);
                        extra_off++; extra_rem--;
                    end
                    r.status = ST_BYTE;
                    r.data = v;
                    r.index = new_pos[15:0];
                    new_pos++;
                    r.last = (new_pos == new_len);
                    if (r.last) ph = PH_DONE;
                end
            end
        endcase
        return r;
    endfunction

    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(2) == 0);
            default: i_stall <= (stall_tick % 7) < 3;
        endcase
    end

    always @(posedge i_clk) begin
        patch_result_t e, g;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout: %0d results outstanding", pending_q.size());
                $display("FAIL");
                $finish;
            end
            if (o_valid && !i_stall) begin
                g = '{o_status, o_out_byte, o_out_index, o_is_last};
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result st=%0d byte=%h idx=%0d last=%0b",
                                 g.status, g.data, g.index, g.last);
                end else begin
                    e = pending_q.pop_front();
                    if (g.status !== e.status || g.data !== e.data || g.index !== e.index
                            || g.last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d byte=%h idx=%0d last=%0b, got st=%0d byte=%h idx=%0d last=%0b",
                                     e.status, e.data, e.index, e.last,
                                     g.status, g.data, g.index, g.last);
                    end
                    case (e.status)
                        ST_BYTE: n_bytes++;
                        ST_ERR: n_err++;
                        ST_DONE: n_done++;
                        default: ;
                    endcase
                end
            end
        end
    end

    task automatic send_req(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d);
        bit stalled;
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_opcode <= op;
        i_address <= a;
        i_data_byte <= d;
        do begin
            #1;
            stalled = o_stall;
            if (stalled) @(negedge i_clk);
        end while (stalled);
        @(posedge i_clk);
        pending_q.push_back(apply_request(op, a, d));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        wait (pending_q.size() == 0);
        // steps that fetch triples keep working a while
        repeat (40) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] a, input u64 val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= a; pwdata <= val[31:0];
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == ADDR_OLD_LEN) reg_old_len = val & 'h1FFFF;
        else reg_patch_len = val & 'h1FFFF;
        @(negedge i_clk);
    endtask

    task automatic put_sm(input int idx, input u64 mag, input bit neg);
        for (int i = 0; i < 8; i++) pimg[idx + i] = mag >> (8 * i);
        pimg[idx + 7][7] = neg;
    endtask

    // well-formed patch for L new bytes; seeks keep old reads below n_old but may go below 0
    task automatic build_patch(input int L, input int n_old, input bit fixed_shape);
        int t_cnt, rem, pos, tgt, a, b, dsum, esum, cb;
        int c0[$], c1[$];
        longint sk[$];
        rem = L; pos = 0; dsum = 0; esum = 0;
        t_cnt = fixed_shape ? 3 : $urandom_range(1, 5);
        for (int k = 0; k < t_cnt; k++) begin
            if (fixed_shape) begin
                a = (k == 1) ? 0 : (k == 0 ? 2 : 1);
                b = a;
            end else begin
                a = $urandom_range(0, rem);
                b = (k == t_cnt - 1) ? rem - a : $urandom_range(0, rem - a);
            end
            if (k > 0) begin
                tgt = int'($urandom_range(0, n_old + 30)) - 30;
                if (tgt > n_old - a) tgt = n_old - a;
                sk.push_back(tgt - pos);
                pos = tgt;
            end
            pos += a; rem -= a + b;
            c0.push_back(a); c1.push_back(b);
            dsum += a; esum += b;
        end
        sk.push_back(int'($urandom_range(0, 60)) - 30);
        pimg.delete();
        for (int k = 0; k < HdrBytes + 24 * t_cnt + dsum + esum; k++)
            pimg.push_back($urandom);
        ctrl_end = HdrBytes + 24 * t_cnt;
        put_sm(8, 24 * t_cnt, 0);
        put_sm(16, dsum, 0);
        put_sm(24, L, 0);
        for (int k = 0; k < t_cnt; k++) begin
            cb = HdrBytes + 24 * k;
            // zero counts sometimes carry a sign bit
            put_sm(cb, c0[k], c0[k] == 0 && $urandom_range(2) == 0);
            put_sm(cb + 8, c1[k], c1[k] == 0 && $urandom_range(2) == 0);
            put_sm(cb + 16, sk[k] < 0 ? -sk[k] : sk[k],
                   sk[k] < 0 || (sk[k] == 0 && $urandom_range(2) == 0));
        end
    endtask

    task automatic load_images(input int n_old);
        for (int i = 0; i < n_old; i++) send_req(OP_LOAD_OLD, i, $urandom);
        foreach (pimg[i]) send_req(OP_LOAD_PATCH, i, pimg[i]);
    endtask

    task automatic run_steps(input int n, input bit noisy, input bit safe);
        send_req(OP_START, $urandom, $urandom);
        n_patches++;
        for (int s = 0; s < n; s++) begin
            if (noisy && $urandom_range(24) == 0) begin
                case ($urandom_range(2))
                    0: send_req(OP_LOAD_OLD, $urandom, $urandom);
                    1: send_req(OP_LOAD_PATCH,
                                safe ? $urandom : $urandom_range(pimg.size(), 65535),
                                $urandom);
                    default: send_req(OP_START, $urandom, $urandom);
                endcase
            end
            send_req(OP_STEP, $urandom, $urandom);
        end
    endtask

    task automatic run_case(input patch_edit_t ed);
        u64 plen;
        wait_idle();
        build_patch(6, 8, 1);
        plen = pimg.size();
        case (ed)
            ED_NEG_COUNT: put_sm(HdrBytes, 2, 1);
            ED_PAST_NEW: put_sm(24, 3, 0);
            ED_PAST_DIFF: put_sm(16, 1, 0);
            ED_PAST_EXTRA: plen = plen - 1;
            ED_RUN_OUT: put_sm(24, 8, 0);
            ED_HDR_NEG: pimg[15][7] = 1'b1;
            ED_HDR_NEW_BIG: put_sm(24, 65537, 0);
            ED_HDR_OVER: plen = ctrl_end + 2;
            ED_HDR_SHORT: plen = HdrBytes - 1;
            ED_NEW_MAX: put_sm(24, 65536, 0);
            ED_NEG_ZERO: put_sm(8, 0, 1);
            default: ;
        endcase
        load_images(8);
        wait_idle();
        cfg_write(ADDR_OLD_LEN, 8);
        cfg_write(ADDR_PATCH_LEN, plen);
        run_steps(8, 0, 1);
    endtask

    task automatic test_idle_and_loads();
        gaps_on = 0; stall_mode = 0;
        send_req(OP_STEP, 16'hFFFF, 8'hFF);
        send_req(OP_LOAD_OLD, 16'hFFFF, 8'hFF);
        send_req(OP_LOAD_OLD, 16'h0000, 8'h00);
        send_req(OP_LOAD_PATCH, 16'hFFFF, 8'h00);
        send_req(OP_LOAD_PATCH, 16'h0000, 8'hFF);
        // header has to be defined before any start
        for (int i = 1; i < HdrBytes; i++) send_req(OP_LOAD_PATCH, i, 8'h00);
        send_req(OP_START, 0, 0);
        send_req(OP_STEP, 0, 0);
    endtask

    task automatic test_good_patch();
        gaps_on = 1; stall_mode = 1;
        run_case(ED_NONE);
        send_req(OP_STEP, 0, 0);
        // restart in the middle of a run
        send_req(OP_START, 0, 0);
        send_req(OP_STEP, 0, 0);
        send_req(OP_START, 0, 0);
        repeat (7) send_req(OP_STEP, 0, 0);
    endtask

    task automatic test_bad_headers();
        gaps_on = 0; stall_mode = 2;
        run_case(ED_HDR_NEG);
        run_case(ED_HDR_NEW_BIG);
        run_case(ED_HDR_OVER);
        run_case(ED_HDR_SHORT);
        run_case(ED_NEG_ZERO);
        run_case(ED_NEW_MAX);
    endtask

    task automatic test_bad_triples();
        gaps_on = 1; stall_mode = 0;
        run_case(ED_NEG_COUNT);
        run_case(ED_PAST_NEW);
        run_case(ED_PAST_DIFF);
        run_case(ED_PAST_EXTRA);
        run_case(ED_RUN_OUT);
    endtask

    task automatic test_random_patches();
        int start_cnt, L, n_old;
        u64 ol, pl;
        bit safe;
        start_cnt = n_sent;
        while (n_sent - start_cnt < 1500) begin
            gaps_on = $urandom_range(1);
            stall_mode = $urandom_range(2);
            L = ($urandom_range(15) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 16);
            n_old = L + $urandom_range(0, 20);
            build_patch(L, n_old, 0);
            case ($urandom_range(9))
                0: ol = 0;
                1: ol = $urandom_range(0, n_old);
                2: ol = 65536;
                3: ol = 131071;
                default: ol = n_old;
            endcase
            case ($urandom_range(9))
                0: pl = $urandom_range(0, pimg.size());
                1: pl = 65536;
                2: pl = 131071;
                default: pl = pimg.size();
            endcase
            // lengths past the loaded data only with intact seeks and counts
            safe = ol <= n_old && pl <= pimg.size();
            if (safe && $urandom_range(3) == 0)
                pimg[$urandom_range(8, ctrl_end - 1)] = $urandom;
            wait_idle();
            load_images(n_old);
            wait_idle();
            cfg_write(ADDR_OLD_LEN, ol);
            cfg_write(ADDR_PATCH_LEN, pl);
            run_steps(L + $urandom_range(0, 2), 1, safe);
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_idle_and_loads();
        test_good_patch();
        test_bad_headers();
        test_bad_triples();
        test_random_patches();
        i_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (40) @(negedge i_clk);
        $display("%0d requests over %0d patch runs: %0d bytes, %0d done, %0d error answers",
                 n_sent, n_patches, n_bytes, n_done, n_err);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
